FILE: rtl/psd_pkg.sv
package psd_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } psd_in_t;

    typedef struct packed {
        logic [63:0] sq_distance;
        logic [16:0] segment_param;
        logic        degenerate;
        logic        saturated;
    } psd_out_t;

    localparam int DIV_STEPS = 16;

    // carried alongside the divider steps
    typedef struct packed {
        logic signed [32:0] w_x;
        logic signed [32:0] w_y;
        logic signed [32:0] w_z;
        logic signed [32:0] v_x;
        logic signed [32:0] v_y;
        logic signed [32:0] v_z;
        logic               degenerate;
    } psd_geom_t;

endpackage

FILE: rtl/psd_dot.sv
// differences, per-axis products, then the two dot-product sums
module psd_dot import psd_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  psd_in_t       in_data,
    output logic          out_valid,
    output psd_geom_t     out_geom,
    output logic signed [67:0] out_dwv,
    output logic [67:0]   out_dvv
);
    logic [2:0]         vld_reg;
    psd_geom_t          g1_reg, g2_reg, g3_reg;
    logic signed [65:0] pwv_reg [3];
    logic [65:0]        pvv_reg [3];
    logic signed [67:0] dwv_reg;
    logic [67:0]        dvv_reg;
    psd_geom_t          g_next;

    always_comb begin
        g_next.w_x = 33'(in_data.point_x) - 33'(in_data.start_x);
        g_next.w_y = 33'(in_data.point_y) - 33'(in_data.start_y);
        g_next.w_z = 33'(in_data.point_z) - 33'(in_data.start_z);
        g_next.v_x = 33'(in_data.end_x) - 33'(in_data.start_x);
        g_next.v_y = 33'(in_data.end_y) - 33'(in_data.start_y);
        g_next.v_z = 33'(in_data.end_z) - 33'(in_data.start_z);
        g_next.degenerate = (in_data.end_x == in_data.start_x) &&
                            (in_data.end_y == in_data.start_y) &&
                            (in_data.end_z == in_data.start_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg <= g_next;
            pwv_reg[0] <= 66'(g1_reg.w_x) * 66'(g1_reg.v_x);
            pwv_reg[1] <= 66'(g1_reg.w_y) * 66'(g1_reg.v_y);
            pwv_reg[2] <= 66'(g1_reg.w_z) * 66'(g1_reg.v_z);
            pvv_reg[0] <= 66'($unsigned(66'(g1_reg.v_x) * 66'(g1_reg.v_x)));
            pvv_reg[1] <= 66'($unsigned(66'(g1_reg.v_y) * 66'(g1_reg.v_y)));
            pvv_reg[2] <= 66'($unsigned(66'(g1_reg.v_z) * 66'(g1_reg.v_z)));
            g2_reg <= g1_reg;
            dwv_reg <= 68'(pwv_reg[0]) + 68'(pwv_reg[1]) + 68'(pwv_reg[2]);
            dvv_reg <= 68'(pvv_reg[0]) + 68'(pvv_reg[1]) + 68'(pvv_reg[2]);
            g3_reg <= g2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_geom  = g3_reg;
    assign out_dwv   = dwv_reg;
    assign out_dvv   = dvv_reg;
endmodule

FILE: rtl/psd_div.sv
// clamp, then one restoring quotient bit per stage
module psd_div import psd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  psd_geom_t          in_geom,
    input  logic signed [67:0] in_dwv,
    input  logic [67:0]        in_dvv,
    output logic               out_valid,
    output psd_geom_t          out_geom,
    output logic [16:0]        out_t
);
    localparam int N = DIV_STEPS + 1;

    logic [N-1:0]  vld_reg;
    psd_geom_t     g_reg [N];
    logic [68:0]   r_reg [N];
    logic [67:0]   d_reg [N];
    logic [16:0]   t_reg [N];
    logic          act_reg [N];

    logic neg_or_zero, ge;
    assign neg_or_zero = in_dwv[67] || (in_dwv == '0);
    assign ge = $unsigned(in_dwv) >= in_dvv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg[0] <= in_geom;
            r_reg[0] <= {1'b0, $unsigned(in_dwv)};
            d_reg[0] <= in_dvv;
            act_reg[0] <= !(in_geom.degenerate || neg_or_zero || ge);
            t_reg[0] <= (!in_geom.degenerate && !neg_or_zero && ge) ? 17'h10000 : '0;
        end
    end

    for (genvar i = 1; i < N; i++) begin : g_step
        logic [68:0] sh;
        logic        bit_ok;
        assign sh = {r_reg[i-1][67:0], 1'b0};
        assign bit_ok = sh >= {1'b0, d_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                g_reg[i]   <= g_reg[i-1];
                d_reg[i]   <= d_reg[i-1];
                act_reg[i] <= act_reg[i-1];
                if (act_reg[i-1]) begin
                    r_reg[i] <= bit_ok ? sh - {1'b0, d_reg[i-1]} : sh;
                    t_reg[i] <= {t_reg[i-1][15:0], bit_ok};
                end else begin
                    r_reg[i] <= r_reg[i-1];
                    t_reg[i] <= t_reg[i-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_geom  = g_reg[N-1];
    assign out_t     = t_reg[N-1];
endmodule

FILE: rtl/psd_dist.sv
// error per axis, squares, sum and saturation
module psd_dist import psd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  psd_geom_t   in_geom,
    input  logic [16:0] in_t,
    output logic        out_valid,
    output psd_out_t    out_data
);
    logic [3:0]         vld_reg;
    logic signed [51:0] vt_reg [3];
    logic signed [48:0] ws_reg [3];
    logic [16:0]        t1_reg, t2_reg, t3_reg, t4_reg;
    logic [1:0]         dg_reg;
    logic               dg3_reg, dg4_reg;
    logic [51:0]        em_reg [3];
    logic [51:0]        hh_reg [3];
    logic [51:0]        hl_reg [3];
    logic [51:0]        ll_reg [3];
    logic [103:0]       sq_reg [3];
    logic [105:0]       sum;
    logic signed [51:0] e [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[i] = 52'(ws_reg[i]) - vt_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vt_reg[0] <= 52'(in_geom.v_x) * 52'($signed({1'b0, in_t}));
            vt_reg[1] <= 52'(in_geom.v_y) * 52'($signed({1'b0, in_t}));
            vt_reg[2] <= 52'(in_geom.v_z) * 52'($signed({1'b0, in_t}));
            ws_reg[0] <= {in_geom.w_x, 16'h0};
            ws_reg[1] <= {in_geom.w_y, 16'h0};
            ws_reg[2] <= {in_geom.w_z, 16'h0};
            t1_reg <= in_t;
            dg_reg[0] <= in_geom.degenerate;
            for (int i = 0; i < 3; i++) begin
                em_reg[i] <= e[i][51] ? 52'(-e[i]) : 52'(e[i]);
                // square split into 26-bit halves
                hh_reg[i] <= 52'(em_reg[i][51:26]) * 52'(em_reg[i][51:26]);
                hl_reg[i] <= 52'(em_reg[i][51:26]) * 52'(em_reg[i][25:0]);
                ll_reg[i] <= 52'(em_reg[i][25:0]) * 52'(em_reg[i][25:0]);
                sq_reg[i] <= (104'(hh_reg[i]) << 52) + (104'(hl_reg[i]) << 27) +
                             104'(ll_reg[i]);
            end
            t2_reg <= t1_reg;
            dg_reg[1] <= dg_reg[0];
            t3_reg <= t2_reg;
            dg3_reg <= dg_reg[1];
            t4_reg <= t3_reg;
            dg4_reg <= dg3_reg;
        end
    end

    assign sum = 106'(sq_reg[0]) + 106'(sq_reg[1]) + 106'(sq_reg[2]);

    always_comb begin
        out_data.segment_param = t4_reg;
        out_data.degenerate    = dg4_reg;
        out_data.saturated     = sum[105:96] != '0;
        out_data.sq_distance   = out_data.saturated ? '1 : sum[95:32];
    end

    assign out_valid = vld_reg[3];
endmodule

FILE: rtl/point_segment_sq_distance_core.sv
// squared distance from a 3d point to a segment, fixed point, fully pipelined
// s_ channel: valid/ready transfer of one query (point, start, end; Q16.16)
// m_ channel: valid/ready transfer of one result (Q32.32 distance, Q1.16 param,
//   degenerate and saturated flags), one result per query, in order
// throughput: one query per cycle while the receiver takes results; the pipeline
//   is 3 dot stages, 17 divider stages (a clamp, then one quotient bit each),
//   4 distance stages and an output register
// a stalled receiver freezes the whole pipeline; the output register holds its
//   result and s_ready drops only when that register is full and not taken
// reset (aresetn low, synchronous) clears all valid bits; no result is pending
// after reset and no clearing pass is needed
module point_segment_sq_distance_core import psd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  psd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output psd_out_t m_data
);
    logic               en;
    logic               dot_valid, div_valid, dist_valid;
    psd_geom_t          dot_geom, div_geom;
    logic signed [67:0] dot_dwv;
    logic [67:0]        dot_dvv;
    logic [16:0]        div_t;
    psd_out_t           dist_data;
    logic               m_valid_reg;
    psd_out_t           m_data_reg;

    // the pipeline advances whenever the output register can take its tail
    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;

    psd_dot u_dot (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready), .in_data(s_data),
        .out_valid(dot_valid), .out_geom(dot_geom),
        .out_dwv(dot_dwv), .out_dvv(dot_dvv)
    );

    psd_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(dot_valid), .in_geom(dot_geom),
        .in_dwv(dot_dwv), .in_dvv(dot_dvv),
        .out_valid(div_valid), .out_geom(div_geom), .out_t(div_t)
    );

    psd_dist u_dist (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(div_valid), .in_geom(div_geom), .in_t(div_t),
        .out_valid(dist_valid), .out_data(dist_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dist_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= dist_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_param: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.segment_param <= 17'h10000)
        else $error("parameter out of range");
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.segment_param == '0)
        else $error("degenerate with nonzero parameter");
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |-> m_data.sq_distance == '1)
        else $error("saturation flag without saturated value");
endmodule

FILE: tb/point_segment_sq_distance_core_test.sv
module point_segment_sq_distance_core_test;
    import psd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 24;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_QUERIES = 1250;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    psd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    psd_out_t m_data;

    psd_in_t  query_q[$];
    psd_out_t expected_q[$];
    int       fail_count = 0;
    int       stall_cycles = 0;
    int       idle_cycles = 0;
    int       hold_off = 0;
    bit       quiet_phase = 1'b0;
    bit       sender_paused = 1'b0;

    point_segment_sq_distance_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // exact fixed-point squared distance and clamped projection parameter
    function automatic psd_out_t segment_distance(psd_in_t q);
        logic signed [33:0]  v[3];
        logic signed [33:0]  w[3];
        logic signed [127:0] dot_wv;
        logic signed [127:0] dot_vv;
        logic [127:0]        rem;
        logic [127:0]        sum;
        logic signed [63:0]  err;
        logic [63:0]         err_mag;
        logic [16:0]         t;
        psd_out_t            r;
        dot_wv = '0;
        dot_vv = '0;
        sum = '0;
        t = '0;
        v[0] = 34'(q.end_x) - 34'(q.start_x);
        v[1] = 34'(q.end_y) - 34'(q.start_y);
        v[2] = 34'(q.end_z) - 34'(q.start_z);
        w[0] = 34'(q.point_x) - 34'(q.start_x);
        w[1] = 34'(q.point_y) - 34'(q.start_y);
        w[2] = 34'(q.point_z) - 34'(q.start_z);
        for (int i = 0; i < 3; i++) begin
            dot_wv += 128'(w[i]) * 128'(v[i]);
            dot_vv += 128'(v[i]) * 128'(v[i]);
        end
        r.degenerate = (dot_vv == 0);
        if (r.degenerate || dot_wv <= 0) begin
            t = '0;
        end else if (dot_wv >= dot_vv) begin
            t = 17'd65536;
        end else begin
            rem = dot_wv;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                t = t << 1;
                if (rem >= dot_vv) begin
                    rem -= dot_vv;
                    t[0] = 1'b1;
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            err = 64'(w[i]) * 64'sd65536 - 64'(v[i]) * $signed({47'd0, t});
            err_mag = err < 0 ? -err : err;
            sum += 128'(err_mag) * 128'(err_mag);
        end
        r.saturated = (sum[127:96] != 0);
        r.sq_distance = r.saturated ? '1 : sum[95:32];
        r.segment_param = t;
        return r;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16);
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    function automatic psd_in_t random_query();
        psd_in_t q;
        q.point_x = random_coord();
        q.point_y = random_coord();
        q.point_z = random_coord();
        q.start_x = random_coord();
        q.start_y = random_coord();
        q.start_z = random_coord();
        case ($urandom_range(0, 9))
            0: begin
                q.end_x = q.start_x;
                q.end_y = q.start_y;
                q.end_z = q.start_z;
            end
            1: begin
                // point on the start end
                q.point_x = q.start_x;
                q.point_y = q.start_y;
                q.point_z = q.start_z;
                q.end_x = random_coord();
                q.end_y = random_coord();
                q.end_z = random_coord();
            end
            2, 3, 4: begin
                // small segments near the point give in-range distances
                q.start_x = q.point_x + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                q.start_y = q.point_y + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                q.start_z = q.point_z + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                q.end_x = q.point_x + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                q.end_y = q.point_y + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                q.end_z = q.point_z + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            default: begin
                q.end_x = random_coord();
                q.end_y = random_coord();
                q.end_z = random_coord();
            end
        endcase
        return q;
    endfunction

    function automatic psd_in_t make_query(int px, int py, int pz, int sx, int sy, int sz,
                                           int ex, int ey, int ez);
        psd_in_t q;
        q.point_x = px; q.point_y = py; q.point_z = pz;
        q.start_x = sx; q.start_y = sy; q.start_z = sz;
        q.end_x = ex; q.end_y = ey; q.end_z = ez;
        return q;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            idle_cycles <= 0;
        end else if (s_valid && !s_ready) begin
            // hold the offered query
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(segment_distance(s_data));
            if (idle_cycles > 0) begin
                idle_cycles <= idle_cycles - 1;
                s_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 19) == 0) begin
                idle_cycles <= $urandom_range(1, 12);
                s_valid <= 1'b0;
            end else if (!sender_paused && query_q.size() > 0) begin
                s_data <= query_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected: %p", $time, m_data);
                    fail_count++;
                end else begin
                    psd_out_t exp_r;
                    exp_r = expected_q.pop_front();
                    if (m_data.sq_distance !== exp_r.sq_distance)
                        $display("%0t: sq_distance expected %h actual %h", $time,
                                 exp_r.sq_distance, m_data.sq_distance);
                    if (m_data.segment_param !== exp_r.segment_param)
                        $display("%0t: segment_param expected %h actual %h", $time,
                                 exp_r.segment_param, m_data.segment_param);
                    if (m_data.degenerate !== exp_r.degenerate)
                        $display("%0t: degenerate expected %b actual %b", $time,
                                 exp_r.degenerate, m_data.degenerate);
                    if (m_data.saturated !== exp_r.saturated)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 exp_r.saturated, m_data.saturated);
                    if (m_data !== exp_r)
                        fail_count++;
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (stall_cycles > 0) begin
                stall_cycles <= stall_cycles - 1;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                stall_cycles <= $urandom_range(1, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else if (++quiet >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(5 << 16, 3 << 16, -1 << 16, 1 << 16, 1 << 16, 1 << 16,
                                     1 << 16, 1 << 16, 1 << 16));
        query_q.push_back(make_query(1 << 16, 1 << 16, 0, 0, 0, 0, 2 << 16, 0, 0));
        query_q.push_back(make_query(-3 << 16, 1 << 16, 0, 0, 0, 0, 2 << 16, 0, 0));
        query_q.push_back(make_query(7 << 16, 1 << 16, 0, 0, 0, 0, 2 << 16, 0, 0));
        query_q.push_back(make_query(2 << 16, 0, 0, 0, 0, 0, 2 << 16, 0, 0));
        query_q.push_back(make_query(1, 2, 3, 0, 0, 0, 3, 7, 11));
        query_q.push_back(make_query(1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 3 << 16, 0, 0));
        query_q.push_back(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h80000000, 32'h80000000));
        query_q.push_back(make_query(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                     32'h80000000, 32'h80000000, 32'h80000000));
        query_q.push_back(make_query(0, 32'h7fffffff, 0, 32'h80000000, 32'h80000000,
                                     32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                     32'h7fffffff));
        query_q.push_back(make_query(-1, -1, -1, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(1 << 16, 0, 0, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(65535, 0, 0, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(0, 1 << 16, 0, 0, 0, 0, 0, 0, 0));
        query_q.push_back(make_query(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                                     32'haaaaaaaa, 32'hffffffff, 32'haaaaaaaa, 32'hffffffff,
                                     32'h55555555));
        query_q.push_back(make_query(0, 0, 0, 1, 0, 0, 2, 0, 0));
        query_q.push_back(make_query(3, 0, 0, 1, 0, 0, 2, 0, 0));
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        wait (query_q.size() == 0);
        wait (expected_q.size() == 0 && !s_valid);

        // receiver holds off while the sender keeps offering
        repeat (200) query_q.push_back(random_query());
        @(posedge aclk);
        hold_off <= 150;
        wait (query_q.size() == 0);

        // sender pauses until every result is back
        @(posedge aclk);
        sender_paused <= 1'b1;
        wait (expected_q.size() == 0 && !s_valid && !m_valid);
        @(posedge aclk);
        sender_paused <= 1'b0;

        repeat (RANDOM_QUERIES - 400) query_q.push_back(random_query());
        wait (query_q.size() == 0);
        @(posedge aclk);
        quiet_phase <= 1'b1;
        repeat (200) query_q.push_back(random_query());
        wait (query_q.size() == 0 && !s_valid);
        wait (expected_q.size() == 0);
        repeat (LATENCY * 4) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
